### hw/rtl/lobm_pkg.sv
`timescale 1ns / 1ps
package lobm_pkg;
   localparam int BOOK_SLOTS_DEF = 32;
   localparam int ID_W = 32;
   localparam int PRICE_W = 16;
   localparam int QTY_W = 24;

   typedef enum logic [2:0] {
      EV_FILL      = 3'd0,
      EV_RESTED    = 3'd1,
      EV_KILLED    = 3'd2,
      EV_CANCELLED = 3'd3,
      EV_NOT_FOUND = 3'd4,
      EV_BOOK_FULL = 3'd5,
      EV_INVALID   = 3'd6
   } event_type;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_CANCEL = 1'b1;
   localparam logic [1:0] SIDE_BUY  = 2'd0;
   localparam logic [1:0] SIDE_SELL = 2'd1;
   localparam logic KIND_MARKET = 1'b1;

   // classified command handed from front to back
   typedef struct packed {
      logic               invalid;
      logic               cancel;
      logic               buy;
      logic               market;
      logic [ID_W-1:0]    id;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } cmd_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [ID_W-1:0]    taker;
      logic [ID_W-1:0]    maker;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
      logic               last;
   } result_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   rem;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CANCEL,
      ST_MATCH,
      ST_REST,
      ST_EMIT
   } state_type;
endpackage

### hw/rtl/lobm_front.sv
`timescale 1ns / 1ps
module lobm_front
   import lobm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               operation,
   input  logic [ID_W-1:0]    order_id,
   input  logic [1:0]         side,
   input  logic               order_kind,
   input  logic [PRICE_W-1:0] price,
   input  logic [QTY_W-1:0]   quantity,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output cmd_type            cmd
);
   // two-entry queue toward the back end
   cmd_type    q_ff [2];
   cmd_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    c;
   logic       push, pop;

   // classify
   always_comb begin
      c.invalid = (side != SIDE_BUY && side != SIDE_SELL) ||
                  (operation == OP_ADD && quantity == '0);
      c.cancel  = (operation == OP_CANCEL);
      c.buy     = (side == SIDE_BUY);
      c.market  = (order_kind == KIND_MARKET);
      c.id      = order_id;
      c.price   = price;
      c.qty     = quantity;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[0];

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         if (pop) q_in[cnt_ff[1]] = c;
         else     q_in[cnt_ff[0]] = c;
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end
endmodule

### hw/rtl/lobm_back.sv
`timescale 1ns / 1ps
module lobm_back
   import lobm_pkg::*;
#(
   parameter int BOOK_SLOTS = BOOK_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   output logic       cmd_ready,
   input  cmd_type    cmd,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);
   localparam int IW = $clog2(BOOK_SLOTS);
   localparam int CW = $clog2(BOOK_SLOTS + 1);
   localparam logic [CW-1:0] FULL = CW'(BOOK_SLOTS);

   // books as register rows with fixed-neighbor shifting
   entry_type  bid_ff [BOOK_SLOTS];
   entry_type  ask_ff [BOOK_SLOTS];
   entry_type  bid_in [BOOK_SLOTS];
   entry_type  ask_in [BOOK_SLOTS];
   logic [CW-1:0] bcnt_ff, bcnt_in, acnt_ff, acnt_in;

   state_type  st_ff, st_in;
   cmd_type    cur_ff, cur_in;
   logic [IW-1:0] idx_ff, idx_in;
   result_type out_ff, out_in;
   logic       ov_ff, ov_in;

   entry_type  own_e, opp_top, ins;
   logic [CW-1:0] own_cnt, opp_cnt;
   logic       crosses, hit, behind;
   logic [QTY_W-1:0] fill;
   logic       out_free;

   assign out_free  = !ov_ff || rsp_ready;
   assign rsp_valid = ov_ff;
   assign rsp       = out_ff;
   assign cmd_ready = (st_ff == ST_IDLE) && out_free;

   always_comb begin
      own_cnt = cur_ff.buy ? bcnt_ff : acnt_ff;
      opp_cnt = cur_ff.buy ? acnt_ff : bcnt_ff;
      own_e   = cur_ff.buy ? bid_ff[idx_ff] : ask_ff[idx_ff];
      opp_top = cur_ff.buy ? ask_ff[0] : bid_ff[0];
      crosses = cur_ff.market ||
                (cur_ff.buy ? (opp_top.price <= cur_ff.price)
                            : (opp_top.price >= cur_ff.price));
      fill    = (opp_top.rem < cur_ff.qty) ? opp_top.rem : cur_ff.qty;
      hit     = (own_e.id == cur_ff.id) && (own_e.price == cur_ff.price);
      behind  = cur_ff.buy ? (own_e.price >= cur_ff.price)
                           : (own_e.price <= cur_ff.price);
      ins.id    = cur_ff.id;
      ins.price = cur_ff.price;
      ins.rem   = cur_ff.qty;
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               if (cmd.invalid)     st_in = ST_IDLE;
               else if (cmd.cancel) st_in = ST_CANCEL;
               else                 st_in = ST_MATCH;
            end
         end
         ST_CANCEL: begin
            if (out_free && (hit || CW'(idx_ff) + 1'b1 >= own_cnt)) st_in = ST_IDLE;
         end
         ST_MATCH: begin
            if (out_free) begin
               if (opp_cnt == '0 || !crosses) begin
                  if (cur_ff.market || own_cnt >= FULL) st_in = ST_IDLE;
                  else st_in = ST_REST;
               end else if (fill == cur_ff.qty) st_in = ST_IDLE;
            end
         end
         ST_REST: begin
            if (CW'(idx_ff) >= own_cnt || !behind) st_in = ST_EMIT;
         end
         ST_EMIT: if (out_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // datapath and results
   always_comb begin
      cur_in = cur_ff;
      idx_in = idx_ff;
      out_in = out_ff;
      ov_in  = ov_ff && !rsp_ready;
      bid_in = bid_ff;
      ask_in = ask_ff;
      bcnt_in = bcnt_ff;
      acnt_in = acnt_ff;
      case (st_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cur_in = cmd;
               idx_in = '0;
               if (cmd.invalid) begin
                  ov_in = 1'b1;
                  out_in = '{EV_INVALID, cmd.id, '0, cmd.price, cmd.qty, 1'b1};
               end
            end
         end
         ST_CANCEL: begin
            if (CW'(idx_ff) >= own_cnt) begin
               // only reached on an empty book
               if (out_free) begin
                  ov_in = 1'b1;
                  out_in = '{EV_NOT_FOUND, cur_ff.id, '0, cur_ff.price, '0, 1'b1};
               end
            end else if (hit) begin
               if (out_free) begin
                  ov_in = 1'b1;
                  out_in = '{EV_CANCELLED, cur_ff.id, '0, cur_ff.price, own_e.rem, 1'b1};
                  for (int i = 0; i < BOOK_SLOTS - 1; i++) begin
                     if (i >= int'(idx_ff)) begin
                        if (cur_ff.buy) bid_in[i] = bid_ff[i+1];
                        else            ask_in[i] = ask_ff[i+1];
                     end
                  end
                  if (cur_ff.buy) bcnt_in = bcnt_ff - 1'b1;
                  else            acnt_in = acnt_ff - 1'b1;
               end
            end else if (CW'(idx_ff) + 1'b1 >= own_cnt) begin
               if (out_free) begin
                  ov_in = 1'b1;
                  out_in = '{EV_NOT_FOUND, cur_ff.id, '0, cur_ff.price, '0, 1'b1};
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_MATCH: begin
            if (out_free) begin
               if (opp_cnt == '0 || !crosses) begin
                  if (cur_ff.market) begin
                     ov_in = 1'b1;
                     out_in = '{EV_KILLED, cur_ff.id, '0, cur_ff.price, cur_ff.qty, 1'b1};
                  end else if (own_cnt >= FULL) begin
                     ov_in = 1'b1;
                     out_in = '{EV_BOOK_FULL, cur_ff.id, '0, cur_ff.price, cur_ff.qty, 1'b1};
                  end
                  idx_in = '0;
               end else begin
                  ov_in = 1'b1;
                  out_in = '{EV_FILL, cur_ff.id, opp_top.id, opp_top.price, fill,
                             fill == cur_ff.qty};
                  cur_in.qty = cur_ff.qty - fill;
                  if (opp_top.rem == fill) begin
                     for (int i = 0; i < BOOK_SLOTS - 1; i++) begin
                        if (cur_ff.buy) ask_in[i] = ask_ff[i+1];
                        else            bid_in[i] = bid_ff[i+1];
                     end
                     if (cur_ff.buy) acnt_in = acnt_ff - 1'b1;
                     else            bcnt_in = bcnt_ff - 1'b1;
                  end else begin
                     if (cur_ff.buy) ask_in[0].rem = opp_top.rem - fill;
                     else            bid_in[0].rem = opp_top.rem - fill;
                  end
               end
            end
         end
         ST_REST: begin
            // scan for the insert slot, then shift and place
            if (CW'(idx_ff) >= own_cnt || !behind) begin
               for (int i = BOOK_SLOTS - 1; i > 0; i--) begin
                  if (i > int'(idx_ff)) begin
                     if (cur_ff.buy) bid_in[i] = bid_ff[i-1];
                     else            ask_in[i] = ask_ff[i-1];
                  end
               end
               if (cur_ff.buy) begin
                  bid_in[idx_ff] = ins;
                  bcnt_in = bcnt_ff + 1'b1;
               end else begin
                  ask_in[idx_ff] = ins;
                  acnt_in = acnt_ff + 1'b1;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ov_in = 1'b1;
               out_in = '{EV_RESTED, cur_ff.id, '0, cur_ff.price, cur_ff.qty, 1'b1};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      out_ff <= out_in;
      bid_ff <= bid_in;
      ask_ff <= ask_in;
      if (reset) begin
         st_ff   <= ST_IDLE;
         ov_ff   <= 1'b0;
         bcnt_ff <= '0;
         acnt_ff <= '0;
      end else begin
         st_ff   <= st_in;
         ov_ff   <= ov_in;
         bcnt_ff <= bcnt_in;
         acnt_ff <= acnt_in;
      end
   end
endmodule

### hw/rtl/limit_order_book_matcher_core.sv
`timescale 1ns / 1ps
// Price-time priority matcher with a bid book and an ask book.
// req_ channel: one beat is an add or cancel command.
// rsp_ channel: one or more result beats per command; rsp_last_event marks
// the final beat of each command.
// A front stage classifies commands into a two-entry queue; the back engine
// walks the books one step per cycle, except where a result beat waits on rsp_ready.
// An invalid command is answered from the idle state; a cancel scans its own
// book until it hits or passes the last order; an add fills against the top
// of the opposite book, then is killed (market), refused (book full) or
// scans its own book for its slot behind equal or better prices and rests.
// The back engine handles one command at a time; the longest is an add that
// sweeps the opposite book and then scans a nearly full own book (one fill
// per step, then one scan step per order ahead of it).
// Reset empties both books and the queue; no clearing pass is needed.
// A stalled rsp_ready holds the result register and stalls the engine where
// it would emit a result; req_ready drops once the queue is full.
module limit_order_book_matcher_core
   import lobm_pkg::*;
#(
   parameter int BOOK_SLOTS = BOOK_SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [ID_W-1:0]    req_order_id,
   input  logic [1:0]         req_side,
   input  logic               req_order_kind,
   input  logic [PRICE_W-1:0] req_price,
   input  logic [QTY_W-1:0]   req_quantity,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_event_kind,
   output logic [ID_W-1:0]    rsp_taker_id,
   output logic [ID_W-1:0]    rsp_maker_id,
   output logic [PRICE_W-1:0] rsp_trade_price,
   output logic [QTY_W-1:0]   rsp_event_quantity,
   output logic               rsp_last_event
);
   cmd_type    cmd;
   logic       cmd_valid, cmd_ready;
   result_type res;

   lobm_front u_front (
      .clock, .reset, .req_valid, .req_ready,
      .operation(req_operation), .order_id(req_order_id), .side(req_side),
      .order_kind(req_order_kind), .price(req_price), .quantity(req_quantity),
      .cmd_valid, .cmd_ready, .cmd
   );

   lobm_back #(.BOOK_SLOTS(BOOK_SLOTS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .rsp_valid, .rsp_ready, .rsp(res)
   );

   assign rsp_event_kind     = res.kind;
   assign rsp_taker_id       = res.taker;
   assign rsp_maker_id       = res.maker;
   assign rsp_trade_price    = res.price;
   assign rsp_event_quantity = res.qty;
   assign rsp_last_event     = res.last;
endmodule
